[hdl/ledfw_pkg.sv]
package ledfw_pkg;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_SYSTEM = 3'd1;
    localparam logic [2:0] ACT_TIME   = 3'd2;
    localparam logic [2:0] ACT_RAW    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_ON = 2'd1;
    localparam logic [1:0] CFG_SLEEP_MODE = 2'd2;

    localparam logic [7:0] CMD_SYSTEM  = 8'h48;
    localparam logic [7:0] CMD_DIGIT0  = 8'h68;
    localparam logic [7:0] DOT_BIT     = 8'h80;
    localparam logic [7:0] KEYSCAN_OFF = 8'h80;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    localparam logic [5:0] TICK_START_HI = 6'd0;
    localparam logic [5:0] TICK_START_LO = 6'd1;
    localparam logic [5:0] TICK_STOP_LO  = 6'd38;
    localparam logic [5:0] TICK_STOP_RISE = 6'd39;
    localparam logic [5:0] TICK_LAST     = 6'd40;
    localparam logic [2:0] FRAMES_FULL   = 3'd4;

    typedef logic [15:0] frame_t;

    function automatic logic [7:0] seg_code(logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0:    r = 8'h3F;
            4'd1:    r = 8'h06;
            4'd2:    r = 8'h5B;
            4'd3:    r = 8'h4F;
            4'd4:    r = 8'h66;
            4'd5:    r = 8'h6D;
            4'd6:    r = 8'h7D;
            4'd7:    r = 8'h07;
            4'd8:    r = 8'h7F;
            4'd9:    r = 8'h6F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // tens digit of a value below 64
    function automatic logic [3:0] tens_of(logic [5:0] v);
        logic [3:0] r;
        if (v >= 6'd60)      r = 4'd6;
        else if (v >= 6'd50) r = 4'd5;
        else if (v >= 6'd40) r = 4'd4;
        else if (v >= 6'd30) r = 4'd3;
        else if (v >= 6'd20) r = 4'd2;
        else if (v >= 6'd10) r = 4'd1;
        else                 r = 4'd0;
        return r;
    endfunction

    function automatic logic [3:0] units_of(logic [5:0] v);
        logic [6:0] prod;
        logic [5:0] diff;
        prod = {3'd0, tens_of(v)} * 7'd10;
        diff = v - prod[5:0];
        return diff[3:0];
    endfunction

    function automatic frame_t digit_frame(logic [1:0] idx, logic [7:0] seg);
        logic [7:0] cmd;
        cmd = CMD_DIGIT0 | {5'd0, idx, 1'b0};
        return {cmd, seg};
    endfunction

    // returns {scl, sda} for tick t of a frame
    function automatic logic [1:0] line_levels(frame_t frame, logic [5:0] t);
        logic [5:0] tm;
        logic [4:0] b;
        logic [4:0] idx_lo;
        logic       dbit;
        logic [1:0] r;
        tm = t - 6'd2;
        b = tm[5:1];
        idx_lo = 5'd16 - b;
        if (b < 5'd8)                    dbit = frame[4'd15 - b[3:0]];
        else if (b == 5'd8 || b >= 5'd17) dbit = 1'b1;
        else                             dbit = frame[idx_lo[3:0]];
        if (t == TICK_START_HI)       r = 2'b11;
        else if (t == TICK_START_LO)  r = 2'b10;
        else if (t == TICK_STOP_LO)   r = 2'b00;
        else if (t == TICK_STOP_RISE) r = 2'b10;
        else if (t >= TICK_LAST)      r = 2'b11;
        else                          r = {tm[0], dbit};
        return r;
    endfunction

endpackage

[hdl/led_driver_two_wire_frame_writer_unit.sv]
// Two-wire frame writer for a four-digit seven-segment LED driver.
// Input channel (in_valid/in_ready): one transfer per bus half-period tick,
// optionally carrying a command (system params, show time, raw digit, clear).
// Output channel (out_valid/out_ready): one transfer per input tick with the
// clock and data line levels for that tick, busy and rejected flags.
// Config channel (cfg_valid/cfg_ready): always ready; writes brightness,
// display_on or sleep_mode by index; other indexes are ignored.
// The result of a tick is registered and presented in the cycle after its transfer.
// Throughput: one tick per cycle while the receiver does not stall; the frame
// sequencer (tick, slot, pending counters) and the result register advance once per accepted tick.
// A command queues one or four frames of 41 ticks each; commands that
// arrive while frames are pending, or a time out of range, are rejected.
// Reset clears the counters, empties the result register and loads the
// config defaults (brightness 0, display on, sleep off).
// When the receiver stalls, the result is held and in_ready drops until the
// result register is taken.
module led_driver_two_wire_frame_writer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [1:0] digit_index,
    input  logic [7:0] seg_pattern,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_line,
    output logic       sda_line,
    output logic       busy_res,
    output logic       rejected,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);

    logic [2:0] brightness_reg;
    logic       display_on_reg;
    logic       sleep_mode_reg;

    ledfw_pkg::frame_t store_reg [4];
    logic [2:0] pend_reg;
    logic [1:0] slot_reg;
    logic [5:0] tick_reg;

    logic [2:0] pend_next;
    logic [1:0] slot_next;
    logic [5:0] tick_next;

    logic out_valid_reg;
    logic scl_reg, sda_reg, busy_reg, rej_reg;
    logic scl_next, sda_next, busy_next, rej_next;

    logic in_fire;
    logic is_cmd;
    logic start;
    logic write_all;
    ledfw_pkg::frame_t new_frame [4];
    ledfw_pkg::frame_t cur_frame;
    logic [2:0] pend_c;
    logic [1:0] slot_c;
    logic [5:0] tick_c;
    logic [1:0] lv;
    logic       time_bad;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign scl_line  = scl_reg;
    assign sda_line  = sda_reg;
    assign busy_res  = busy_reg;
    assign rejected  = rej_reg;

    always_comb
    begin
        new_frame[0] = ledfw_pkg::digit_frame(2'd0, ledfw_pkg::seg_code(
            ledfw_pkg::tens_of({1'b0, hour})));
        new_frame[1] = ledfw_pkg::digit_frame(2'd1, ledfw_pkg::seg_code(
            ledfw_pkg::units_of({1'b0, hour})) | ledfw_pkg::DOT_BIT);
        new_frame[2] = ledfw_pkg::digit_frame(2'd2,
            ledfw_pkg::seg_code(ledfw_pkg::tens_of(minute)));
        new_frame[3] = ledfw_pkg::digit_frame(2'd3,
            ledfw_pkg::seg_code(ledfw_pkg::units_of(minute)));
        is_cmd    = (action == ledfw_pkg::ACT_SYSTEM) || (action == ledfw_pkg::ACT_TIME)
                 || (action == ledfw_pkg::ACT_RAW) || (action == ledfw_pkg::ACT_CLEAR);
        time_bad  = (hour > ledfw_pkg::HOUR_MAX) || (minute > ledfw_pkg::MINUTE_MAX);
        rej_next  = 1'b0;
        start     = 1'b0;
        write_all = 1'b0;
        pend_c    = pend_reg;
        case (action)
            ledfw_pkg::ACT_SYSTEM:
            begin
                new_frame[0] = {ledfw_pkg::CMD_SYSTEM, ledfw_pkg::KEYSCAN_OFF
                    | {1'b0, brightness_reg, 1'b0, sleep_mode_reg, 1'b0, display_on_reg}};
            end
            ledfw_pkg::ACT_RAW:
            begin
                new_frame[0] = ledfw_pkg::digit_frame(digit_index, seg_pattern);
            end
            ledfw_pkg::ACT_CLEAR:
            begin
                new_frame[0] = ledfw_pkg::digit_frame(2'd0, 8'h00);
                new_frame[1] = ledfw_pkg::digit_frame(2'd1, 8'h00);
                new_frame[2] = ledfw_pkg::digit_frame(2'd2, 8'h00);
                new_frame[3] = ledfw_pkg::digit_frame(2'd3, 8'h00);
            end
            default:
            begin
            end
        endcase
        if (is_cmd)
        begin
            if (pend_reg != 3'd0)
                rej_next = 1'b1;
            else if (action == ledfw_pkg::ACT_TIME && time_bad)
                rej_next = 1'b1;
            else
            begin
                start = 1'b1;
                write_all = (action == ledfw_pkg::ACT_TIME) || (action == ledfw_pkg::ACT_CLEAR);
                pend_c = write_all ? ledfw_pkg::FRAMES_FULL : 3'd1;
            end
        end
        slot_c    = start ? 2'd0 : slot_reg;
        tick_c    = start ? 6'd0 : tick_reg;
        cur_frame = start ? new_frame[0] : store_reg[slot_c];
        lv        = ledfw_pkg::line_levels(cur_frame, tick_c);

        scl_next  = 1'b1;
        sda_next  = 1'b1;
        pend_next = pend_c;
        slot_next = slot_c;
        tick_next = tick_c;
        if (pend_c != 3'd0)
        begin
            scl_next = lv[1];
            sda_next = lv[0];
            if (tick_c == ledfw_pkg::TICK_LAST)
            begin
                tick_next = 6'd0;
                slot_next = slot_c + 2'd1;
                pend_next = pend_c - 3'd1;
            end
            else
                tick_next = tick_c + 6'd1;
        end
        busy_next = (pend_next != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 3'd0;
            display_on_reg <= 1'b1;
            sleep_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ledfw_pkg::CFG_BRIGHTNESS: brightness_reg <= cfg_data;
                ledfw_pkg::CFG_DISPLAY_ON: display_on_reg <= cfg_data[0];
                ledfw_pkg::CFG_SLEEP_MODE: sleep_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 3'd0;
            slot_reg      <= 2'd0;
            tick_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pend_reg <= pend_next;
                slot_reg <= slot_next;
                tick_reg <= tick_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scl_reg  <= scl_next;
            sda_reg  <= sda_next;
            busy_reg <= busy_next;
            rej_reg  <= rej_next;
            if (start)
            begin
                store_reg[0] <= new_frame[0];
                if (write_all)
                begin
                    store_reg[1] <= new_frame[1];
                    store_reg[2] <= new_frame[2];
                    store_reg[3] <= new_frame[3];
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= ledfw_pkg::FRAMES_FULL)
        else $error("frame count out of range");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != 6'd0) |-> (pend_reg != 3'd0))
        else $error("tick counter running with no frame pending");

    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (scl_line && sda_line))
        else $error("lines not high when idle");

    a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pend_reg != 3'd0 && is_cmd) |=> rejected)
        else $error("command accepted while busy");
`endif

endmodule
